// File: src/dpt_pkg.sv
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared types, codes and defaults of the detector pairing table.
// ----------------------------------------------------------------------------
package dpt_pkg;

    localparam int DPT_ENTRIES = 32;

    // request modes
    localparam logic [2:0] MODE_LEARN    = 3'd0;
    localparam logic [2:0] MODE_MATCH    = 3'd1;
    localparam logic [2:0] MODE_PRESENCE = 3'd2;
    localparam logic [2:0] MODE_READ     = 3'd3;
    localparam logic [2:0] MODE_WRITE    = 3'd4;
    localparam logic [2:0] MODE_CLEAR    = 3'd5;
    localparam logic [2:0] MODE_VALIDATE = 3'd6;

    // result status codes
    localparam logic [2:0] ST_KNOWN    = 3'd0;
    localparam logic [2:0] ST_ADDED    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_OK       = 3'd4;
    localparam logic [2:0] ST_BADIDX   = 3'd5;
    localparam logic [2:0] ST_INVCLR   = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_TYPE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_ZONE_COUNT   = 2'd1;
    localparam logic [1:0] CFG_CLEARED_TYPE = 2'd2;
    localparam logic [1:0] CFG_CLEARED_ZONE = 2'd3;

    localparam logic [3:0] RST_TYPE_COUNT   = 4'd3;
    localparam logic [3:0] RST_ZONE_COUNT   = 4'd3;
    localparam logic [3:0] RST_CLEARED_TYPE = 4'd1;
    localparam logic [3:0] RST_CLEARED_ZONE = 4'd1;

    localparam logic [7:0] NOT_FOUND_ID = 8'hff;

    typedef struct packed {
        logic [15:0] node;
        logic [63:0] code_lo;
        logic [31:0] code_hi;
        logic [3:0]  zone;
        logic [3:0]  dtype;
        logic [7:0]  id;
        logic        valid;
    } t_entry;

    // outcome of the shared compare unit for one entry
    typedef struct packed {
        logic full_hit;
        logic node_hit;
        logic free;
        logic bad;
    } t_eval;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  hit_slot;
        logic [7:0]  id;
        logic        valid;
        logic [3:0]  dtype;
        logic [3:0]  zone;
        logic [31:0] code_hi;
        logic [63:0] code_lo;
        logic [15:0] node;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_RD   = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

endpackage

// File: src/dpt_store.sv
// ----------------------------------------------------------------------------
// dpt_store
// Entry memory with one write port, one registered read port and a written
// bit per entry; an entry not written since the last clear reads as cleared.
// ----------------------------------------------------------------------------
module dpt_store #(
    parameter int ENTRIES = dpt_pkg::DPT_ENTRIES,
    parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clr,
    input  logic [3:0]      i_clr_type,
    input  logic [3:0]      i_clr_zone,
    input  logic            i_we,
    input  logic [IW-1:0]   i_waddr,
    input  dpt_pkg::t_entry i_wdata,
    input  logic [IW-1:0]   i_raddr,
    output dpt_pkg::t_entry o_rdata
);
    import dpt_pkg::*;

    t_entry               mem [ENTRIES];
    t_entry               r_rd;
    logic                 r_rd_wr;
    logic [ENTRIES-1:0]   r_written;
    logic [3:0]           r_clr_type;
    logic [3:0]           r_clr_zone;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rd    <= mem[i_raddr];
        r_rd_wr <= r_written[i_raddr];
    end

    // clear all drops every written bit and keeps the type/zone to show
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written  <= '0;
            r_clr_type <= RST_CLEARED_TYPE;
            r_clr_zone <= RST_CLEARED_ZONE;
        end else if (i_clr) begin
            r_written  <= '0;
            r_clr_type <= i_clr_type;
            r_clr_zone <= i_clr_zone;
        end else if (i_we) begin
            r_written[i_waddr] <= 1'b1;
        end
    end

    always_comb begin
        if (r_rd_wr) begin
            o_rdata = r_rd;
        end else begin
            o_rdata       = '0;
            o_rdata.dtype = r_clr_type;
            o_rdata.zone  = r_clr_zone;
        end
    end

endmodule

// File: src/dpt_eval.sv
// ----------------------------------------------------------------------------
// dpt_eval
// Shared compare unit: checks one entry against the request key and the
// configured type and zone limits.
// ----------------------------------------------------------------------------
module dpt_eval #(
    parameter int ENTRIES = dpt_pkg::DPT_ENTRIES
) (
    input  dpt_pkg::t_entry i_entry,
    input  logic [31:0]     i_code_hi,
    input  logic [63:0]     i_code_lo,
    input  logic [15:0]     i_node,
    input  logic [3:0]      i_type_count,
    input  logic [3:0]      i_zone_count,
    output dpt_pkg::t_eval  o_eval
);
    import dpt_pkg::*;

    logic node_eq;

    assign node_eq         = (i_entry.node == i_node);
    assign o_eval.node_hit = i_entry.valid && node_eq;
    assign o_eval.full_hit = i_entry.valid && node_eq && (i_entry.code_hi == i_code_hi)
                             && (i_entry.code_lo == i_code_lo);
    assign o_eval.free     = !i_entry.valid;
    assign o_eval.bad      = (i_entry.id > 8'(ENTRIES)) || (i_entry.dtype >= i_type_count)
                             || (i_entry.zone >= i_zone_count);

endmodule

// File: src/detector_pairing_table.sv
// ----------------------------------------------------------------------------
// detector_pairing_table
// Table of paired wireless detectors: learn, match, presence, read, write,
// clear all and validate requests, one result item per request.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                      tuser
//  s_axis    in         request fields (144 bits)  mode (3 bits)
//  m_axis    out        result fields (144 bits)   status (3 bits)
//  i_cfg     in         4-bit register value       -
//
//  Learn, match and validate scan the memory through its one read port;
//  learn and match end the scan early on a hit. Presence and read read one
//  entry; write, clear all and rejects go straight to the final state.
//  Clear all acts on the written bits only; reset needs no sweep.
//  The input stays ready while a result waits; a busy request holds in
//  its final state until the output register frees.
// ----------------------------------------------------------------------------
module detector_pairing_table #(
    parameter int ENTRIES = dpt_pkg::DPT_ENTRIES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // config write port
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [3:0]    i_cfg_data,
    // request stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // slot[7:0] new_id[15:8] new_valid[16] dev_type[20:17] zone_kind[24:21]
    // code_upper[56:25] code_lower[120:57] node_addr[136:121] zero[143:137]
    input  logic [143:0]  s_axis_tdata,
    // mode[2:0]
    input  logic [2:0]    s_axis_tuser,
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // hit_slot[7:0] out_id[15:8] out_valid[16] out_type[20:17] out_zone[24:21]
    // out_code_upper[56:25] out_code_lower[120:57] out_node[136:121] zero[143:137]
    output logic [143:0]  m_axis_tdata,
    // status[2:0]
    output logic [2:0]    m_axis_tuser
);
    import dpt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // request fields
    logic [7:0]  in_slot;
    logic [7:0]  in_new_id;
    logic        in_new_valid;
    logic [3:0]  in_dev_type;
    logic [3:0]  in_zone_kind;
    logic [31:0] in_code_upper;
    logic [63:0] in_code_lower;
    logic [15:0] in_node_addr;
    logic        slot_bad;
    logic        accept;

    assign in_slot       = s_axis_tdata[7:0];
    assign in_new_id     = s_axis_tdata[15:8];
    assign in_new_valid  = s_axis_tdata[16];
    assign in_dev_type   = s_axis_tdata[20:17];
    assign in_zone_kind  = s_axis_tdata[24:21];
    assign in_code_upper = s_axis_tdata[56:25];
    assign in_code_lower = s_axis_tdata[120:57];
    assign in_node_addr  = s_axis_tdata[136:121];
    assign slot_bad      = (in_slot >= 8'(ENTRIES));

    // config registers
    logic [3:0] r_type_count;
    logic [3:0] r_zone_count;
    logic [3:0] r_cleared_type;
    logic [3:0] r_cleared_zone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_count   <= RST_TYPE_COUNT;
            r_zone_count   <= RST_ZONE_COUNT;
            r_cleared_type <= RST_CLEARED_TYPE;
            r_cleared_zone <= RST_CLEARED_ZONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TYPE_COUNT:   r_type_count   <= i_cfg_data;
                CFG_ZONE_COUNT:   r_zone_count   <= i_cfg_data;
                CFG_CLEARED_TYPE: r_cleared_type <= i_cfg_data;
                CFG_CLEARED_ZONE: r_cleared_zone <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer state
    t_state        r_state, n_state;
    logic [2:0]    r_mode, n_mode;
    logic [CW-1:0] r_addr, n_addr;
    logic [IW-1:0] r_cidx, n_cidx;
    logic          r_pend, n_pend;
    logic          r_free_fnd, n_free_fnd;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic          r_bad, n_bad;
    t_res          r_res, n_res;
    logic [31:0]   r_key_hi, n_key_hi;
    logic [63:0]   r_key_lo, n_key_lo;
    logic [15:0]   r_key_node, n_key_node;
    logic [3:0]    r_key_type, n_key_type;
    logic [3:0]    r_key_zone, n_key_zone;
    t_res          r_out;
    logic          r_ovalid;

    // memory and compare unit hookup
    logic          st_clr;
    logic          st_we;
    logic [IW-1:0] st_waddr;
    t_entry        st_wdata;
    t_entry        rd_entry;
    t_eval         ev;
    logic          last;
    logic          out_free;
    logic          free_now;
    logic [IW-1:0] free_idx_now;

    dpt_store #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (st_clr),
        .i_clr_type (r_cleared_type),
        .i_clr_zone (r_cleared_zone),
        .i_we       (st_we),
        .i_waddr    (st_waddr),
        .i_wdata    (st_wdata),
        .i_raddr    (r_addr[IW-1:0]),
        .o_rdata    (rd_entry)
    );

    dpt_eval #(
        .ENTRIES (ENTRIES)
    ) u_eval (
        .i_entry      (rd_entry),
        .i_code_hi    (r_key_hi),
        .i_code_lo    (r_key_lo),
        .i_node       (r_key_node),
        .i_type_count (r_type_count),
        .i_zone_count (r_zone_count),
        .o_eval       (ev)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign last          = (r_cidx == IW'(ENTRIES - 1));
    assign free_now      = r_free_fnd || ev.free;
    assign free_idx_now  = r_free_fnd ? r_free_idx : r_cidx;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_addr     = r_addr;
        n_cidx     = r_cidx;
        n_pend     = r_pend;
        n_free_fnd = r_free_fnd;
        n_free_idx = r_free_idx;
        n_bad      = r_bad;
        n_res      = r_res;
        n_key_hi   = r_key_hi;
        n_key_lo   = r_key_lo;
        n_key_node = r_key_node;
        n_key_type = r_key_type;
        n_key_zone = r_key_zone;
        st_clr     = 1'b0;
        st_we      = 1'b0;
        st_waddr   = r_addr[IW-1:0];
        st_wdata   = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode     = s_axis_tuser;
                    n_key_hi   = in_code_upper;
                    n_key_lo   = in_code_lower;
                    n_key_node = in_node_addr;
                    n_key_type = in_dev_type;
                    n_key_zone = in_zone_kind;
                    n_res      = '0;
                    n_pend     = 1'b0;
                    n_free_fnd = 1'b0;
                    n_bad      = 1'b0;
                    n_state    = S_FIN;
                    case (s_axis_tuser)
                        MODE_LEARN, MODE_MATCH, MODE_VALIDATE: begin
                            n_addr  = '0;
                            n_state = S_SCAN;
                        end
                        MODE_PRESENCE, MODE_READ: begin
                            if (slot_bad) begin
                                n_res.status = ST_BADIDX;
                            end else begin
                                n_res.status   = ST_OK;
                                n_res.hit_slot = in_slot;
                                n_addr         = CW'(in_slot);
                                n_state        = S_RD;
                            end
                        end
                        MODE_WRITE: begin
                            if (slot_bad) begin
                                n_res.status = ST_BADIDX;
                            end else begin
                                n_res.status     = ST_OK;
                                n_res.hit_slot   = in_slot;
                                st_we            = 1'b1;
                                st_waddr         = IW'(in_slot);
                                st_wdata.valid   = in_new_valid;
                                st_wdata.id      = in_new_id;
                                st_wdata.dtype   = in_dev_type;
                                st_wdata.zone    = in_zone_kind;
                                st_wdata.code_hi = in_code_upper;
                                st_wdata.code_lo = in_code_lower;
                                st_wdata.node    = in_node_addr;
                            end
                        end
                        MODE_CLEAR: begin
                            st_clr       = 1'b1;
                            n_res.status = ST_OK;
                        end
                        default: begin
                            n_res.status = ST_BADIDX;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // issue the next read while the previous entry is checked
                if (r_addr < CW'(ENTRIES)) begin
                    n_cidx = r_addr[IW-1:0];
                    n_pend = 1'b1;
                    n_addr = r_addr + CW'(1);
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    case (r_mode)
                        MODE_LEARN: begin
                            if (ev.full_hit) begin
                                n_res.status   = ST_KNOWN;
                                n_res.hit_slot = 8'(r_cidx);
                                n_res.id       = rd_entry.id;
                                n_state        = S_FIN;
                            end else if (last) begin
                                if (free_now) begin
                                    st_we            = 1'b1;
                                    st_waddr         = free_idx_now;
                                    st_wdata.valid   = 1'b1;
                                    st_wdata.id      = 8'(free_idx_now) + 8'd1;
                                    st_wdata.dtype   = r_key_type;
                                    st_wdata.zone    = r_key_zone;
                                    st_wdata.code_hi = r_key_hi;
                                    st_wdata.code_lo = r_key_lo;
                                    st_wdata.node    = r_key_node;
                                    n_res.status     = ST_ADDED;
                                    n_res.hit_slot   = 8'(free_idx_now);
                                    n_res.id         = 8'(free_idx_now) + 8'd1;
                                end else begin
                                    n_res.status   = ST_FULL;
                                    n_res.hit_slot = 8'(ENTRIES);
                                end
                                n_state = S_FIN;
                            end else if (ev.free && !r_free_fnd) begin
                                n_free_fnd = 1'b1;
                                n_free_idx = r_cidx;
                            end
                        end
                        MODE_MATCH: begin
                            if (ev.node_hit) begin
                                n_res.status   = ST_OK;
                                n_res.hit_slot = 8'(r_cidx);
                                n_res.id       = rd_entry.id;
                                n_state        = S_FIN;
                            end else if (last) begin
                                n_res.status = ST_NOTFOUND;
                                n_res.id     = NOT_FOUND_ID;
                                n_state      = S_FIN;
                            end
                        end
                        default: begin
                            n_bad = r_bad || ev.bad;
                            if (last) begin
                                if (r_bad || ev.bad) begin
                                    st_clr       = 1'b1;
                                    n_res.status = ST_INVCLR;
                                end else begin
                                    n_res.status = ST_OK;
                                end
                                n_state = S_FIN;
                            end
                        end
                    endcase
                end
            end

            S_RD: begin
                if (!r_pend) begin
                    n_pend = 1'b1;
                end else begin
                    n_res.valid = rd_entry.valid;
                    if (r_mode == MODE_READ) begin
                        n_res.id      = rd_entry.id;
                        n_res.dtype   = rd_entry.dtype;
                        n_res.zone    = rd_entry.zone;
                        n_res.code_hi = rd_entry.code_hi;
                        n_res.code_lo = rd_entry.code_lo;
                        n_res.node    = rd_entry.node;
                    end
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                // hold until the output register frees
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend     <= 1'b0;
            r_free_fnd <= 1'b0;
            r_bad      <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend     <= n_pend;
            r_free_fnd <= n_free_fnd;
            r_bad      <= n_bad;
            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_addr     <= n_addr;
        r_cidx     <= n_cidx;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
        r_key_hi   <= n_key_hi;
        r_key_lo   <= n_key_lo;
        r_key_node <= n_key_node;
        r_key_type <= n_key_type;
        r_key_zone <= n_key_zone;
        if (r_state == S_FIN && out_free) begin
            r_out <= r_res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {7'd0, r_out.node, r_out.code_lo, r_out.code_hi, r_out.zone,
                            r_out.dtype, r_out.valid, r_out.id, r_out.hit_slot};

endmodule

// File: test/tb_detector_pairing_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_detector_pairing_table
// Self-checking bench for the detector pairing table. A short scripted
// sequence covers reset contents, out-of-range slots, the unused mode, learn
// hits and misses, and validation of boundary ids. Random phases then follow
// under several register settings, with learn bursts, fill-to-full runs,
// matches, reads, writes, clears and validations. Each result item is
// compared field by field with a scripted answer or a behavioral copy of the table.
// ----------------------------------------------------------------------------
module tb_detector_pairing_table;

    import dpt_pkg::*;

    localparam logic [2:0] MODE_UNUSED = 3'd7;

    localparam int POOL           = 48;
    localparam int NPHASE         = 5;
    localparam int PHASE_ITEMS    = 175;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int TAIL_CYCLES    = 50;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  slot;
        logic [7:0]  new_id;
        logic        new_valid;
        logic [3:0]  dtype;
        logic [3:0]  zone;
        logic [31:0] code_hi;
        logic [63:0] code_lo;
        logic [15:0] node;
    } t_request;

    typedef struct {
        t_request rq;
        bit       typed;
        t_res     golden;
    } t_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_idx;
    logic [3:0]    i_cfg_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    // slot, new_id, new_valid, dev_type, zone_kind, code_upper, code_lower,
    // node_addr, zero pad
    logic [143:0]  s_axis_tdata;
    // mode
    logic [2:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    // hit_slot, out_id, out_valid, out_type, out_zone, out_code_upper,
    // out_code_lower, out_node, zero pad
    logic [143:0]  m_axis_tdata;
    // status
    logic [2:0]    m_axis_tuser;

    // behavioral copy of the table and its registers
    t_entry        pair_tbl [DPT_ENTRIES];
    logic [3:0]    lim_type;
    logic [3:0]    lim_zone;
    logic [3:0]    clr_type;
    logic [3:0]    clr_zone;

    t_res          pending_answers [$];
    int            fail_count;
    int            items_sent;
    int            status_seen [8];
    int            tx_gap_pct;
    int            rx_stall_pct;
    bit            rx_hold_req;

    logic [31:0]   pool_hi [POOL];
    logic [63:0]   pool_lo [POOL];
    logic [15:0]   pool_node [POOL];

    detector_pairing_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void wipe_pair_tbl();
        int i;
        for (i = 0; i < DPT_ENTRIES; i++) begin
            pair_tbl[i]       = '0;
            pair_tbl[i].dtype = clr_type;
            pair_tbl[i].zone  = clr_zone;
        end
    endfunction

    // Apply one request to the table copy and return the answer it gives.
    function automatic t_res predict_answer(t_request rq);
        t_res r;
        int   i;
        int   hit;
        bit   bad;
        r   = '0;
        hit = -1;
        bad = 1'b0;
        case (rq.mode)
            MODE_LEARN: begin
                for (i = 0; i < DPT_ENTRIES && hit < 0; i++)
                    if (pair_tbl[i].valid && pair_tbl[i].code_hi == rq.code_hi &&
                        pair_tbl[i].code_lo == rq.code_lo && pair_tbl[i].node == rq.node)
                        hit = i;
                if (hit >= 0) begin
                    r.status   = ST_KNOWN;
                    r.hit_slot = 8'(hit);
                    r.id       = pair_tbl[hit].id;
                end else begin
                    for (i = 0; i < DPT_ENTRIES && hit < 0; i++)
                        if (!pair_tbl[i].valid)
                            hit = i;
                    if (hit >= 0) begin
                        pair_tbl[hit].valid   = 1'b1;
                        pair_tbl[hit].id      = 8'(hit + 1);
                        pair_tbl[hit].dtype   = rq.dtype;
                        pair_tbl[hit].zone    = rq.zone;
                        pair_tbl[hit].code_hi = rq.code_hi;
                        pair_tbl[hit].code_lo = rq.code_lo;
                        pair_tbl[hit].node    = rq.node;
                        r.status   = ST_ADDED;
                        r.hit_slot = 8'(hit);
                        r.id       = 8'(hit + 1);
                    end else begin
                        r.status   = ST_FULL;
                        r.hit_slot = 8'(DPT_ENTRIES);
                    end
                end
            end
            MODE_MATCH: begin
                for (i = 0; i < DPT_ENTRIES && hit < 0; i++)
                    if (pair_tbl[i].valid && pair_tbl[i].node == rq.node)
                        hit = i;
                if (hit >= 0) begin
                    r.status   = ST_OK;
                    r.hit_slot = 8'(hit);
                    r.id       = pair_tbl[hit].id;
                end else begin
                    r.status = ST_NOTFOUND;
                    r.id     = NOT_FOUND_ID;
                end
            end
            MODE_PRESENCE, MODE_READ, MODE_WRITE: begin
                if (rq.slot >= DPT_ENTRIES) begin
                    r.status = ST_BADIDX;
                end else begin
                    r.status   = ST_OK;
                    r.hit_slot = rq.slot;
                    if (rq.mode == MODE_PRESENCE) begin
                        r.valid = pair_tbl[rq.slot].valid;
                    end else if (rq.mode == MODE_READ) begin
                        r.id      = pair_tbl[rq.slot].id;
                        r.valid   = pair_tbl[rq.slot].valid;
                        r.dtype   = pair_tbl[rq.slot].dtype;
                        r.zone    = pair_tbl[rq.slot].zone;
                        r.code_hi = pair_tbl[rq.slot].code_hi;
                        r.code_lo = pair_tbl[rq.slot].code_lo;
                        r.node    = pair_tbl[rq.slot].node;
                    end else begin
                        pair_tbl[rq.slot].valid   = rq.new_valid;
                        pair_tbl[rq.slot].id      = rq.new_id;
                        pair_tbl[rq.slot].dtype   = rq.dtype;
                        pair_tbl[rq.slot].zone    = rq.zone;
                        pair_tbl[rq.slot].code_hi = rq.code_hi;
                        pair_tbl[rq.slot].code_lo = rq.code_lo;
                        pair_tbl[rq.slot].node    = rq.node;
                    end
                end
            end
            MODE_CLEAR: begin
                wipe_pair_tbl();
                r.status = ST_OK;
            end
            MODE_VALIDATE: begin
                // the valid mark plays no part: every slot is checked
                for (i = 0; i < DPT_ENTRIES; i++)
                    if (pair_tbl[i].id > DPT_ENTRIES || pair_tbl[i].dtype >= lim_type ||
                        pair_tbl[i].zone >= lim_zone)
                        bad = 1'b1;
                if (bad) begin
                    wipe_pair_tbl();
                    r.status = ST_INVCLR;
                end else begin
                    r.status = ST_OK;
                end
            end
            default: r.status = ST_BADIDX;
        endcase
        return r;
    endfunction

    function automatic t_request mk_req(logic [2:0] mode, logic [7:0] slot,
                                        logic [7:0] new_id, logic new_valid,
                                        logic [3:0] dtype, logic [3:0] zone,
                                        logic [31:0] code_hi, logic [63:0] code_lo,
                                        logic [15:0] node);
        t_request rq;
        rq.mode      = mode;
        rq.slot      = slot;
        rq.new_id    = new_id;
        rq.new_valid = new_valid;
        rq.dtype     = dtype;
        rq.zone      = zone;
        rq.code_hi   = code_hi;
        rq.code_lo   = code_lo;
        rq.node      = node;
        return rq;
    endfunction

    function automatic t_res short_res(logic [2:0] status, logic [7:0] hit_slot,
                                       logic [7:0] id);
        t_res r;
        r          = '0;
        r.status   = status;
        r.hit_slot = hit_slot;
        r.id       = id;
        return r;
    endfunction

    // Random request; unless fresh, code and node mostly come from the pool
    // so that learns repeat and matches hit.
    function automatic t_request random_request(logic [2:0] mode, bit fresh);
        t_request rq;
        int       k;
        k            = $urandom_range(0, POOL - 1);
        rq.mode      = mode;
        rq.slot      = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, DPT_ENTRIES - 1))
                                                    : 8'($urandom);
        rq.new_id    = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(1, DPT_ENTRIES))
                                                   : 8'($urandom);
        rq.new_valid = 1'($urandom);
        rq.dtype     = ($urandom_range(0, 1) == 1) ? 4'($urandom_range(0, lim_type - 1))
                                                   : 4'($urandom);
        rq.zone      = ($urandom_range(0, 1) == 1) ? 4'($urandom_range(0, lim_zone - 1))
                                                   : 4'($urandom);
        rq.code_hi   = $urandom;
        rq.code_lo   = {$urandom, $urandom};
        rq.node      = 16'($urandom);
        if (!fresh && $urandom_range(0, 99) < 80) begin
            rq.code_hi = pool_hi[k];
            rq.code_lo = pool_lo[k];
            rq.node    = pool_node[k];
        end
        return rq;
    endfunction

    // Offer one item, hold it until accepted, then record what it should give.
    task automatic send_request(input t_request rq, input bit typed, input t_res golden);
        t_res want;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.mode;
        s_axis_tdata  <= {7'd0, rq.node, rq.code_lo, rq.code_hi, rq.zone, rq.dtype,
                          rq.new_valid, rq.new_id, rq.slot};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        want = predict_answer(rq);
        if (typed)
            want = golden;
        pending_answers.push_back(want);
        items_sent++;
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain_answers();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_registers(input logic [3:0] tc, input logic [3:0] zc,
                                  input logic [3:0] ct, input logic [3:0] cz);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TYPE_COUNT;
        i_cfg_data <= tc;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ZONE_COUNT;
        i_cfg_data <= zc;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CLEARED_TYPE;
        i_cfg_data <= ct;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CLEARED_ZONE;
        i_cfg_data <= cz;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        lim_type = tc;
        lim_zone = zc;
        clr_type = ct;
        clr_zone = cz;
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                for (hold_left = RX_HOLD_CYCLES; hold_left > 0; hold_left--)
                    @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                // the edge at the top of the loop also counts toward the stall
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : answer_check
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_answers.size() == 0) begin
                $error("result item with nothing pending, status %0d", m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                status_seen[want.status]++;
                check_field("status", want.status, m_axis_tuser);
                check_field("hit_slot", want.hit_slot, m_axis_tdata[7:0]);
                check_field("out_id", want.id, m_axis_tdata[15:8]);
                check_field("out_valid", want.valid, m_axis_tdata[16]);
                check_field("out_type", want.dtype, m_axis_tdata[20:17]);
                check_field("out_zone", want.zone, m_axis_tdata[24:21]);
                check_field("out_code_upper", want.code_hi, m_axis_tdata[56:25]);
                check_field("out_code_lower", want.code_lo, m_axis_tdata[120:57]);
                check_field("out_node", want.node, m_axis_tdata[136:121]);
                check_field("pad", '0, m_axis_tdata[143:137]);
            end
        end
    end

    // end the run if nothing moves on either side for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_row       script [$];
        t_res       g;
        int         p;
        int         k;
        int         n;
        int         kind;
        int         first;
        bit         held;
        bit         paused;
        logic [3:0] tc;
        logic [3:0] zc;
        logic [3:0] ct;
        logic [3:0] cz;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_TYPE_COUNT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_LEARN;
        fail_count    = 0;
        items_sent    = 0;
        rx_hold_req   = 1'b0;
        tx_gap_pct    = 20;
        rx_stall_pct  = 20;
        foreach (status_seen[k])
            status_seen[k] = 0;
        lim_type = RST_TYPE_COUNT;
        lim_zone = RST_ZONE_COUNT;
        clr_type = RST_CLEARED_TYPE;
        clr_zone = RST_CLEARED_ZONE;
        wipe_pair_tbl();

        for (k = 0; k < POOL; k++) begin
            pool_hi[k]   = $urandom;
            pool_lo[k]   = {$urandom, $urandom};
            // some detectors share a node so a match must return the first
            pool_node[k] = (k % 8 == 7) ? pool_node[k - 1] : 16'($urandom);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        g       = short_res(ST_OK, 8'd0, 8'd0);
        g.dtype = RST_CLEARED_TYPE;
        g.zone  = RST_CLEARED_ZONE;
        script.push_back('{mk_req(MODE_READ, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '0),
                           1'b1, g});
        script.push_back('{mk_req(MODE_PRESENCE, 8'd31, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '0),
                           1'b1, short_res(ST_OK, 8'd31, 8'd0)});
        script.push_back('{mk_req(MODE_READ, 8'd32, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '0),
                           1'b1, short_res(ST_BADIDX, 8'd0, 8'd0)});
        script.push_back('{mk_req(MODE_WRITE, 8'hff, 8'hff, 1'b1, 4'hf, 4'hf, '1, '1, '1),
                           1'b1, short_res(ST_BADIDX, 8'd0, 8'd0)});
        script.push_back('{mk_req(MODE_PRESENCE, 8'd200, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '0),
                           1'b1, short_res(ST_BADIDX, 8'd0, 8'd0)});
        // empty slots hold node zero but must not match
        script.push_back('{mk_req(MODE_MATCH, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '0),
                           1'b1, short_res(ST_NOTFOUND, 8'd0, NOT_FOUND_ID)});
        script.push_back('{mk_req(MODE_VALIDATE, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '0),
                           1'b1, short_res(ST_OK, 8'd0, 8'd0)});
        script.push_back('{mk_req(MODE_UNUSED, 8'hff, 8'hff, 1'b1, 4'hf, 4'hf, '1, '1, '1),
                           1'b1, short_res(ST_BADIDX, 8'd0, 8'd0)});
        script.push_back('{mk_req(MODE_LEARN, 8'hff, 8'hff, 1'b1, 4'hf, 4'hf, '1, '1, '1),
                           1'b1, short_res(ST_ADDED, 8'd0, 8'd1)});
        script.push_back('{mk_req(MODE_LEARN, 8'd0, 8'd0, 1'b0, 4'hf, 4'hf, '1, '1, '1),
                           1'b1, short_res(ST_KNOWN, 8'd0, 8'd1)});
        script.push_back('{mk_req(MODE_LEARN, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '0),
                           1'b1, short_res(ST_ADDED, 8'd1, 8'd2)});
        // same code, other node: a new detector
        script.push_back('{mk_req(MODE_LEARN, 8'd0, 8'd0, 1'b0, 4'd2, 4'd0, '1, '1, 16'h0001),
                           1'b1, short_res(ST_ADDED, 8'd2, 8'd3)});
        script.push_back('{mk_req(MODE_MATCH, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '1),
                           1'b1, short_res(ST_OK, 8'd0, 8'd1)});
        script.push_back('{mk_req(MODE_MATCH, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '0),
                           1'b1, short_res(ST_OK, 8'd1, 8'd2)});
        script.push_back('{mk_req(MODE_READ, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '0),
                           1'b0, '0});
        script.push_back('{mk_req(MODE_WRITE, 8'd31, 8'hff, 1'b1, 4'hf, 4'hf, $urandom,
                                  {$urandom, $urandom}, 16'h1234),
                           1'b1, short_res(ST_OK, 8'd31, 8'd0)});
        script.push_back('{mk_req(MODE_READ, 8'd31, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '0),
                           1'b0, '0});
        script.push_back('{mk_req(MODE_VALIDATE, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '0),
                           1'b1, short_res(ST_INVCLR, 8'd0, 8'd0)});
        script.push_back('{mk_req(MODE_READ, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '0),
                           1'b0, '0});
        // id equal to the table size is still a good id
        script.push_back('{mk_req(MODE_WRITE, 8'd5, 8'd32, 1'b0, 4'd2, 4'd2, '0, '0, '0),
                           1'b1, short_res(ST_OK, 8'd5, 8'd0)});
        script.push_back('{mk_req(MODE_VALIDATE, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '0),
                           1'b1, short_res(ST_OK, 8'd0, 8'd0)});
        script.push_back('{mk_req(MODE_WRITE, 8'd6, 8'd33, 1'b1, 4'd0, 4'd0, '0, '0, '0),
                           1'b1, short_res(ST_OK, 8'd6, 8'd0)});
        script.push_back('{mk_req(MODE_VALIDATE, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '0),
                           1'b1, short_res(ST_INVCLR, 8'd0, 8'd0)});
        script.push_back('{mk_req(MODE_CLEAR, 8'd0, 8'd0, 1'b0, 4'd0, 4'd0, '0, '0, '0),
                           1'b1, short_res(ST_OK, 8'd0, 8'd0)});

        foreach (script[k])
            send_request(script[k].rq, script[k].typed, script[k].golden);

        for (p = 0; p < NPHASE; p++) begin
            drain_answers();
            if (p == 0) begin
                tc = 4'd15; zc = 4'd15; ct = 4'd0; cz = 4'd0;
            end else if (p == 1) begin
                tc = 4'd1; zc = 4'd1; ct = 4'd15; cz = 4'd15;
            end else begin
                tc = 4'($urandom_range(1, 15));
                zc = 4'($urandom_range(1, 15));
                ct = 4'($urandom_range(0, 15));
                cz = 4'($urandom_range(0, 15));
            end
            load_registers(tc, zc, ct, cz);
            // the last phase runs with no idling on either side
            tx_gap_pct   = (p == NPHASE - 1) ? 0 : $urandom_range(0, 2) * 20;
            rx_stall_pct = (p == NPHASE - 1) ? 0 : $urandom_range(0, 2) * 20;
            first  = items_sent;
            held   = 1'b0;
            paused = 1'b0;
            while (items_sent - first < PHASE_ITEMS) begin
                if (p == 0 && !held && items_sent - first >= PHASE_ITEMS / 2) begin
                    // hold the result side while requests keep coming
                    rx_hold_req = 1'b1;
                    held        = 1'b1;
                end
                if (p == 2 && !paused && items_sent - first >= PHASE_ITEMS / 2) begin
                    drain_answers();
                    paused = 1'b1;
                end
                kind = $urandom_range(0, 99);
                if (kind < 35) begin
                    n = $urandom_range(1, 8);
                    repeat (n) send_request(random_request(MODE_LEARN, 1'b0), 1'b0, '0);
                end else if (kind < 50) begin
                    send_request(random_request(MODE_MATCH, 1'b0), 1'b0, '0);
                end else if (kind < 60) begin
                    send_request(random_request(MODE_PRESENCE, 1'b0), 1'b0, '0);
                end else if (kind < 70) begin
                    send_request(random_request(MODE_READ, 1'b0), 1'b0, '0);
                end else if (kind < 80) begin
                    send_request(random_request(MODE_WRITE, 1'b0), 1'b0, '0);
                end else if (kind < 85) begin
                    send_request(random_request(MODE_CLEAR, 1'b1), 1'b0, '0);
                end else if (kind < 92) begin
                    send_request(random_request(MODE_VALIDATE, 1'b1), 1'b0, '0);
                end else if (kind < 95) begin
                    send_request(random_request(MODE_UNUSED, 1'b1), 1'b0, '0);
                end else begin
                    // empty the table, then learn past its size
                    send_request(random_request(MODE_CLEAR, 1'b1), 1'b0, '0);
                    repeat (DPT_ENTRIES + 3)
                        send_request(random_request(MODE_LEARN, 1'b1), 1'b0, '0);
                end
            end
        end

        drain_answers();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d requests over %0d register settings, with stalls on both sides.",
                 items_sent, NPHASE + 1);
        $display("By status: known %0d, added %0d, full %0d, not found %0d, ok %0d, %s %0d, %s %0d",
                 status_seen[ST_KNOWN], status_seen[ST_ADDED], status_seen[ST_FULL],
                 status_seen[ST_NOTFOUND], status_seen[ST_OK], "bad index",
                 status_seen[ST_BADIDX], "invalid cleared", status_seen[ST_INVCLR]);
        if (fail_count == 0 && pending_answers.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
